/* design/assert_macros.svh */
// assertion macros for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/ffea_pkg.sv */
// types and codes for the first-fit extent allocator
package ffea_pkg;
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] block_size;
    logic [31:0] block_offset;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] granted_offset;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_FRD, S_FCHK, S_FNX, S_FNXCHK,
    S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR, S_INS, S_DONE
  } state_e;
endpackage

/* design/first_fit_extent_allocator_core.sv */
// first-fit extent allocator: sorted extent table in ram, one entry per step
//   channel  dir  handshake              payload
//   req      in   req_valid_i/req_ready_o req_i
//   rsp      out  rsp_valid_o/rsp_ready_i rsp_o
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i
// an item reads and checks each scanned entry, and reads and writes each
// shifted entry (one ram read port); clear goes straight to the done state
// reset sets the table to one extent of pool size, no clearing pass
// req is not ready from acceptance until the result transfer
`include "assert_macros.svh"
module first_fit_extent_allocator_core #(
  parameter int MAX_EXTENTS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ffea_pkg::req_t        req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output ffea_pkg::rsp_t        rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i
);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int AW = ADDR_BITS;
  localparam logic [AW-1:0] AMAX = '1;

  logic [2*AW-1:0] mem_q [MAX_EXTENTS];
  logic [2*AW-1:0] rd_q;
  logic [IW-1:0]   raddr, waddr;
  logic [2*AW-1:0] wdata;
  logic            we;

  ffea_pkg::state_e state_q, state_d;
  logic [31:0]   pool_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] tgt_q, tgt_d;
  logic [1:0]    op_q;
  logic [AW-1:0] size_q, off_q;
  logic [AW-1:0] ps_q, ps_d, pl_q, pl_d;
  logic [AW-1:0] ns_q, ns_d, nl_q, nl_d;
  logic [1:0]    mode_q, mode_d;
  ffea_pkg::rsp_t rsp_q, rsp_d;
  logic [AW-1:0] pool_a;
  logic          init_q;
  logic          rd0_q;
  logic [2*AW-1:0] rd_fix;
  logic [2*AW-1:0] rd_e;
  logic          mprev, mnext, eq_join;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_EQ   = 2'd1;

  logic [AW-1:0] e_s, e_l;
  assign e_s = rd_e[2*AW-1:AW];
  assign e_l = rd_e[AW-1:0];

  function automatic logic [AW-1:0] sat(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW] ? AMAX : s[AW-1:0];
  endfunction

  function automatic logic tch(input logic [AW-1:0] s, input logic [AW-1:0] l,
                               input logic [AW-1:0] n);
    logic [AW:0] e;
    e = {1'b0, s} + {1'b0, l};
    return !e[AW] && (e[AW-1:0] == n);
  endfunction

  assign pool_a = AW'(pool_q);

  // reads of entry 0 before its first write see the reset extent
  assign rd_fix = {{AW{1'b0}}, AW'(32'hFFFF_FFFF)};
  assign rd_e = rd0_q ? rd_fix : rd_q;

  assign mprev = (idx_q != '0) && tch(ps_q, pl_q, off_q);
  assign mnext = (idx_q < cnt_q) && tch(off_q, size_q, ns_q);
  assign eq_join = (idx_q + 1'b1 < cnt_q) && tch(ns_q, nl_q, e_s);

  assign req_ready_o = (state_q == ffea_pkg::S_IDLE) && !rsp_valid_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffea_pkg::S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          if ((req_i.opcode == ffea_pkg::OP_ALLOC || req_i.opcode == ffea_pkg::OP_FREE) &&
              AW'(req_i.block_size) != '0) begin
            state_d = (req_i.opcode == ffea_pkg::OP_ALLOC) ? ffea_pkg::S_RD
                                                           : ffea_pkg::S_FRD;
          end else state_d = ffea_pkg::S_DONE;
        end
      end
      ffea_pkg::S_RD: begin
        if (idx_q >= cnt_q) state_d = ffea_pkg::S_DONE;
        else state_d = ffea_pkg::S_CHK;
      end
      ffea_pkg::S_CHK: begin
        if (e_l == size_q) state_d = ffea_pkg::S_SHL_RD;
        else if (e_l > size_q) state_d = ffea_pkg::S_DONE;
        else state_d = ffea_pkg::S_RD;
      end
      ffea_pkg::S_SHL_RD: begin
        if (tgt_q + 1'b1 >= cnt_q) state_d = ffea_pkg::S_DONE;
        else state_d = ffea_pkg::S_SHL_WR;
      end
      ffea_pkg::S_SHL_WR: state_d = ffea_pkg::S_SHL_RD;
      ffea_pkg::S_FRD: begin
        if (idx_q >= cnt_q) state_d = ffea_pkg::S_FNXCHK;
        else state_d = ffea_pkg::S_FCHK;
      end
      ffea_pkg::S_FCHK: begin
        if (e_s < off_q) state_d = ffea_pkg::S_FRD;
        else if (e_s == off_q) state_d = ffea_pkg::S_FNX;
        else state_d = ffea_pkg::S_FNXCHK;
      end
      ffea_pkg::S_FNX: state_d = ffea_pkg::S_FNXCHK;
      ffea_pkg::S_FNXCHK: begin
        state_d = ffea_pkg::S_DONE;
        if (mode_q == M_EQ) begin
          if (eq_join) state_d = ffea_pkg::S_SHL_RD;
        end else if (mprev && mnext) begin
          state_d = ffea_pkg::S_SHL_RD;
        end else if (!mprev && !mnext && cnt_q < CW'(MAX_EXTENTS)) begin
          state_d = ffea_pkg::S_SHR_RD;
        end
      end
      ffea_pkg::S_SHR_RD: begin
        if (tgt_q == idx_q) state_d = ffea_pkg::S_INS;
        else state_d = ffea_pkg::S_SHR_WR;
      end
      ffea_pkg::S_SHR_WR: state_d = ffea_pkg::S_SHR_RD;
      ffea_pkg::S_INS: state_d = ffea_pkg::S_DONE;
      ffea_pkg::S_DONE: state_d = ffea_pkg::S_IDLE;
      default: state_d = ffea_pkg::S_IDLE;
    endcase
  end

  // datapath and table access
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; tgt_d = tgt_q;
    ps_d = ps_q; pl_d = pl_q; ns_d = ns_q; nl_d = nl_q; mode_d = mode_q;
    rsp_d = rsp_q;
    raddr = idx_q[IW-1:0]; waddr = idx_q[IW-1:0]; wdata = '0; we = 1'b0;
    case (state_q)
      ffea_pkg::S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          idx_d = '0;
          rsp_d = '{ok: 1'b0, granted_offset: '0, status: ffea_pkg::ST_NOFIT};
          if ((req_i.opcode == ffea_pkg::OP_ALLOC || req_i.opcode == ffea_pkg::OP_FREE) &&
              AW'(req_i.block_size) == '0) begin
            rsp_d.status = ffea_pkg::ST_ZERO;
          end
        end
      end
      ffea_pkg::S_CHK: begin
        if (e_l == size_q) begin
          rsp_d = '{ok: 1'b1, granted_offset: 32'(e_s), status: ffea_pkg::ST_OK};
          tgt_d = idx_q;
        end else if (e_l > size_q) begin
          rsp_d = '{ok: 1'b1, granted_offset: 32'(e_s), status: ffea_pkg::ST_OK};
          we = 1'b1;
          wdata = {e_s + size_q, e_l - size_q};
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // remove entry tgt: shift left from tgt+1 to cnt-1
      ffea_pkg::S_SHL_RD: begin
        raddr = IW'(tgt_q + 1'b1);
        if (tgt_q + 1'b1 >= cnt_q) cnt_d = cnt_q - 1'b1;
      end
      ffea_pkg::S_SHL_WR: begin
        we = 1'b1; waddr = tgt_q[IW-1:0]; wdata = rd_e;
        tgt_d = tgt_q + 1'b1;
      end
      ffea_pkg::S_FRD: begin
        if (idx_q >= cnt_q) mode_d = M_NONE;
      end
      ffea_pkg::S_FCHK: begin
        if (e_s < off_q) begin
          ps_d = e_s; pl_d = e_l;
          idx_d = idx_q + 1'b1;
        end else begin
          ns_d = e_s; nl_d = e_l;
          if (e_s == off_q) begin
            nl_d = sat(e_l, size_q);
            mode_d = M_EQ;
          end else begin
            mode_d = M_NONE;
          end
        end
      end
      // equal start: read p+1
      ffea_pkg::S_FNX: begin
        raddr = IW'(idx_q + 1'b1);
      end
      ffea_pkg::S_FNXCHK: begin
        rsp_d = '{ok: 1'b1, granted_offset: '0, status: ffea_pkg::ST_OK};
        if (mode_q == M_EQ) begin
          we = 1'b1;
          if (eq_join) begin
            wdata = {ns_q, sat(nl_q, e_l)};
            tgt_d = idx_q + 1'b1;
          end else wdata = {ns_q, nl_q};
        end else begin
          if (mprev && mnext) begin
            we = 1'b1; waddr = IW'(idx_q - 1'b1);
            wdata = {ps_q, sat(sat(pl_q, size_q), nl_q)};
            tgt_d = idx_q;
          end else if (mprev) begin
            we = 1'b1; waddr = IW'(idx_q - 1'b1);
            wdata = {ps_q, sat(pl_q, size_q)};
          end else if (mnext) begin
            we = 1'b1;
            wdata = {off_q, sat(nl_q, size_q)};
          end else if (cnt_q >= CW'(MAX_EXTENTS)) begin
            rsp_d.ok = 1'b0; rsp_d.status = ffea_pkg::ST_FULL;
          end else begin
            tgt_d = cnt_q;
          end
        end
      end
      // make room: move entry tgt-1 to tgt down to idx
      ffea_pkg::S_SHR_RD: begin
        raddr = IW'(tgt_q - 1'b1);
      end
      ffea_pkg::S_SHR_WR: begin
        we = 1'b1; waddr = tgt_q[IW-1:0]; wdata = rd_e;
        tgt_d = tgt_q - 1'b1;
      end
      ffea_pkg::S_INS: begin
        we = 1'b1; wdata = {off_q, size_q};
        cnt_d = cnt_q + 1'b1;
      end
      ffea_pkg::S_DONE: begin
        if (op_q == ffea_pkg::OP_CLEAR) begin
          rsp_d = '{ok: 1'b1, granted_offset: '0, status: ffea_pkg::ST_OK};
          we = 1'b1; waddr = '0; wdata = {{AW{1'b0}}, pool_a};
          cnt_d = (pool_a != '0) ? CW'(1) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  logic rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffea_pkg::S_IDLE;
      pool_q <= 32'hFFFF_FFFF;
      cnt_q <= CW'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_valid_i) pool_q <= cfg_data_i;
      if (state_q == ffea_pkg::S_DONE) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  // entry 0 holds the reset extent until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b0;
    else if (we && waddr == '0) init_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; tgt_q <= tgt_d; mode_q <= mode_d;
    ps_q <= ps_d; pl_q <= pl_d; ns_q <= ns_d; nl_q <= nl_d;
    rsp_q <= rsp_d;
    rd0_q <= (raddr == '0) && !init_q;
    if (req_valid_i && req_ready_o) begin
      op_q <= req_i.opcode;
      size_q <= AW'(req_i.block_size);
      off_q <= AW'(req_i.block_offset);
    end
  end

  `ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_EXTENTS))
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)
  `ASSERT_IMPL(a_rsp_ok, clk_i, rst_ni, rsp_valid_o, rsp_o.ok == (rsp_o.status == ffea_pkg::ST_OK))
endmodule
